// File: src/kpt_pkg.sv
// ----------------------------------------------------------------------------
// kpt_pkg
// Shared types, constants and helpers for the kerning pair table.
// ----------------------------------------------------------------------------
package kpt_pkg;

  localparam int MAX_PAIRS = 32;
  localparam int ADDR_W    = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
  localparam int COUNT_W   = $clog2(MAX_PAIRS + 1);
  localparam int CODE_W    = 8;
  localparam int AMOUNT_W  = 8;
  localparam int ENTRY_W   = 2 * CODE_W + AMOUNT_W;

  localparam logic signed [31:0] AMOUNT_MIN = -32'sd128;
  localparam logic signed [31:0] AMOUNT_MAX = 32'sd127;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_LOOKUP = 2'd1,
    ACT_CLEAR  = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [CODE_W-1:0]          left;
    logic [CODE_W-1:0]          right;
    logic signed [AMOUNT_W-1:0] amount;
  } pair_t;

  // Clamp a 32-bit signed amount into the 8-bit signed range.
  function automatic logic signed [AMOUNT_W-1:0] sat_amount(input logic signed [31:0] a);
    logic signed [AMOUNT_W-1:0] r;
    if (a < AMOUNT_MIN) begin
      r = AMOUNT_MIN[AMOUNT_W-1:0];
    end else if (a > AMOUNT_MAX) begin
      r = AMOUNT_MAX[AMOUNT_W-1:0];
    end else begin
      r = a[AMOUNT_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: src/kerning_pair_table.sv
// Flow: insert, clear, unused codes and a lookup that skips the scan (wide
//   code or empty table) go from idle through the done state to the result; a
//   scanning lookup first reads stored pairs up to a match or the newest entry.
// Throughput: one request at a time; the scan reads one stored pair per cycle
//   through the single read port of the pair memory.
// Reset: empties the table (count to zero) and drops any pending result.
// ----------------------------------------------------------------------------
// kerning_pair_table
// Bounded table of kerning pairs with append, first-match lookup and clear.
// ----------------------------------------------------------------------------
module kerning_pair_table (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_stall,
  input  logic [1:0]                          action,
  input  logic [31:0]                         left_code,
  input  logic [31:0]                         right_code,
  input  logic signed [31:0]                  adjust_amount,
  output logic                                res_valid,
  input  logic                                res_stall,
  output logic signed [kpt_pkg::AMOUNT_W-1:0] kern_value,
  output logic                                insert_accepted
);

  import kpt_pkg::*;

  state_t state, state_next;

  logic [COUNT_W-1:0]         pair_count;
  logic [COUNT_W-1:0]         scan_idx;     // next entry to read
  logic                       scan_live;    // read data valid this cycle
  logic                       scan_last;    // that read was the newest entry
  logic [CODE_W-1:0]          key_left;
  logic [CODE_W-1:0]          key_right;
  logic signed [AMOUNT_W-1:0] pend_kern;
  logic                       pend_acc;

  logic  accept;
  logic  table_full;
  logic  codes_narrow;
  logic  do_insert;
  logic  start_scan;
  logic  scan_hit;
  logic  scan_end;
  logic  scan_issue;
  logic  res_free;
  logic  load_result;
  pair_t wr_pair;
  pair_t rd_pair;

  assign accept       = req_valid && !req_stall;
  assign table_full   = (pair_count == COUNT_W'(MAX_PAIRS));
  assign codes_narrow = (left_code[31:CODE_W] == '0) && (right_code[31:CODE_W] == '0);
  assign do_insert    = accept && (action == ACT_INSERT) && !table_full;
  // Skip the scan when a code is out of range or the table is empty.
  assign start_scan   = accept && (action == ACT_LOOKUP) && codes_narrow &&
                        (pair_count != '0);
  assign scan_hit     = scan_live && (rd_pair.left == key_left) &&
                        (rd_pair.right == key_right);
  assign scan_end     = scan_live && (scan_hit || scan_last);
  assign res_free     = !res_valid || !res_stall;

  assign wr_pair.left   = left_code[CODE_W-1:0];
  assign wr_pair.right  = right_code[CODE_W-1:0];
  assign wr_pair.amount = sat_amount(adjust_amount);

  // Pair memory: appended at pair_count, scanned from entry 0 upward.
  kpt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_PAIRS)
  ) u_pair_ram (
    .clk     (clk),
    .wr_en   (do_insert),
    .wr_addr (pair_count[ADDR_W-1:0]),
    .wr_data (wr_pair),
    .rd_en   (scan_issue),
    .rd_addr (scan_idx[ADDR_W-1:0]),
    .rd_data (rd_pair)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = start_scan ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    req_stall   = 1'b1;
    scan_issue  = 1'b0;
    load_result = 1'b0;
    unique case (state)
      ST_IDLE: req_stall   = 1'b0;
      // Keep reading until the pair in hand ends the scan.
      ST_SCAN: scan_issue  = !scan_end && !(scan_live && scan_last);
      ST_DONE: load_result = res_free;
      default: req_stall   = 1'b1;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      pair_count <= '0;
      scan_idx   <= '0;
      scan_live  <= 1'b0;
      scan_last  <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      state     <= state_next;
      scan_live <= scan_issue;
      if (do_insert) begin
        pair_count <= pair_count + COUNT_W'(1);
      end else if (accept && (action == ACT_CLEAR)) begin
        pair_count <= '0;
      end
      if (accept) begin
        scan_idx  <= '0;
        scan_last <= 1'b0;
      end else if (scan_issue) begin
        scan_idx  <= scan_idx + COUNT_W'(1);
        scan_last <= (scan_idx == pair_count - COUNT_W'(1));
      end
      // Hold the result until taken; load a new one when the slot frees.
      if (load_result) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      key_left  <= left_code[CODE_W-1:0];
      key_right <= right_code[CODE_W-1:0];
      pend_kern <= '0;
      pend_acc  <= do_insert;
    end else if (scan_hit && (state == ST_SCAN)) begin
      pend_kern <= rd_pair.amount;
    end
    if (load_result) begin
      kern_value      <= pend_kern;
      insert_accepted <= pend_acc;
    end
  end

  // Checks.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    pair_count <= COUNT_W'(MAX_PAIRS))
    else $error("pair count exceeds table size");

  a_write_idle: assert property (@(posedge clk) disable iff (rst)
    do_insert |-> (state == ST_IDLE) && !table_full)
    else $error("pair write outside idle or into full table");

  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    scan_issue |-> (scan_idx < pair_count))
    else $error("scan reads beyond stored pairs");

  a_done_loads: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) && !res_valid |=> res_valid)
    else $error("finished request not delivered");

endmodule

// File: src/kpt_ram.sv
// ----------------------------------------------------------------------------
// kpt_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module kpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                           clk,
  input  logic                                           wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   wr_addr,
  input  logic [WIDTH-1:0]                               wr_data,
  input  logic                                           rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   rd_addr,
  output logic [WIDTH-1:0]                               rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
